// File: src/wea_pkg.sv
// shared types and codes for the word error alignment counter
// no dependencies
`default_nettype none

package wea_pkg;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] token;
    } t_in;

    typedef struct packed {
        logic [31:0] sub_total;
        logic [31:0] del_total;
        logic [31:0] ins_total;
        logic [31:0] cor_total;
        logic        dropped;
    } t_out;

    localparam logic [1:0] OP_LOAD_REF = 2'd0;
    localparam logic [1:0] OP_LOAD_HYP = 2'd1;
    localparam logic [1:0] OP_ALIGN    = 2'd2;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_DEL  = 2'd1,
        DIR_INS  = 2'd2,
        DIR_DIAG = 2'd3
    } t_dir;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_ROW,
        ST_RD,
        ST_CALC,
        ST_TB_RD,
        ST_TB_EX,
        ST_FIN
    } t_state;

endpackage

`default_nettype wire

// File: src/word_error_alignment_counter_core.sv
// load: one word transfer per cycle; align: fills the grid row by row, a read state
// and a calc state per grid cell through the cost row ram, then traces back a path
// of max(nr,nh) to nr+nh steps, a read and an execute state per step via the dir ram
// input stall is high for the whole align; one item at a time
// synchronous active-low reset clears lengths, flags and totals; rams are not cleared
// depends on wea_pkg and wea_ram
`default_nettype none

module word_error_alignment_counter_core #(
    parameter int MAX_REF_WORDS = 64,
    parameter int MAX_HYP_WORDS = 64,
    parameter int TOKEN_BITS    = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output      logic          o_in_stall,
    input  wire wea_pkg::t_in  i_in_data,
    output      logic          o_out_valid,
    input  wire logic          i_out_stall,
    output      wea_pkg::t_out o_out_data
);
    import wea_pkg::*;

    localparam int TW   = (TOKEN_BITS < 32) ? TOKEN_BITS : 32;
    localparam int RAW  = (MAX_REF_WORDS > 1) ? $clog2(MAX_REF_WORDS) : 1;
    localparam int HAW  = (MAX_HYP_WORDS > 1) ? $clog2(MAX_HYP_WORDS) : 1;
    localparam int IW   = $clog2(MAX_REF_WORDS + 1);
    localparam int JW   = $clog2(MAX_HYP_WORDS + 1);
    localparam int CW   = $clog2(MAX_REF_WORDS + MAX_HYP_WORDS + 2);
    localparam int DD   = (MAX_REF_WORDS + 1) * (MAX_HYP_WORDS + 1);
    localparam int DAW  = $clog2(DD);
    localparam logic [DAW-1:0] GC    = DAW'(MAX_HYP_WORDS + 1);
    localparam logic [IW-1:0]  MAX_R = IW'(MAX_REF_WORDS);
    localparam logic [JW-1:0]  MAX_H = JW'(MAX_HYP_WORDS);

    t_state          r_state, n_state;
    logic [IW-1:0]   r_ref_len, n_ref_len;
    logic [JW-1:0]   r_hyp_len, n_hyp_len;
    logic            r_ovf, n_ovf;
    logic [IW-1:0]   r_i, n_i;
    logic [JW-1:0]   r_j, n_j;
    logic [DAW-1:0]  r_base, n_base;
    logic [CW-1:0]   r_diag, n_diag;
    logic [CW-1:0]   r_left, n_left;
    logic [31:0]     r_sub, n_sub;
    logic [31:0]     r_del, n_del;
    logic [31:0]     r_ins, n_ins;
    logic [31:0]     r_cor, n_cor;
    logic            r_out_valid, n_out_valid;
    t_out            r_out, n_out;

    logic            ref_we, hyp_we, cost_we, dir_we;
    logic [RAW-1:0]  ref_wa;
    logic [HAW-1:0]  hyp_wa;
    logic [JW-1:0]   cost_wa;
    logic [CW-1:0]   cost_wd;
    logic [DAW-1:0]  dir_wa;
    t_dir            dir_wd;
    logic [IW-1:0]   i_m1;
    logic [JW-1:0]   j_m1;
    logic [DAW-1:0]  dir_ra;
    logic [TW-1:0]   ref_rd, hyp_rd;
    logic [CW-1:0]   cost_rd;
    logic [1:0]      dir_rd;
    logic [1:0]      dir_wd_bits;

    assign i_m1        = r_i - IW'(1);
    assign j_m1        = r_j - JW'(1);
    assign dir_ra      = r_base + DAW'(r_j);
    assign dir_wd_bits = dir_wd;

    wea_ram #(.WIDTH(TW), .DEPTH(MAX_REF_WORDS)) u_ref_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ref_we),
        .i_wr_addr (ref_wa),
        .i_wr_data (i_in_data.token[TW-1:0]),
        .i_rd_addr (i_m1[RAW-1:0]),
        .o_rd_data (ref_rd)
    );

    wea_ram #(.WIDTH(TW), .DEPTH(MAX_HYP_WORDS)) u_hyp_ram (
        .i_clk     (i_clk),
        .i_wr_en   (hyp_we),
        .i_wr_addr (hyp_wa),
        .i_wr_data (i_in_data.token[TW-1:0]),
        .i_rd_addr (j_m1[HAW-1:0]),
        .o_rd_data (hyp_rd)
    );

    wea_ram #(.WIDTH(CW), .DEPTH(MAX_HYP_WORDS + 1)) u_cost_ram (
        .i_clk     (i_clk),
        .i_wr_en   (cost_we),
        .i_wr_addr (cost_wa),
        .i_wr_data (cost_wd),
        .i_rd_addr (r_j),
        .o_rd_data (cost_rd)
    );

    wea_ram #(.WIDTH(2), .DEPTH(DD)) u_dir_ram (
        .i_clk     (i_clk),
        .i_wr_en   (dir_we),
        .i_wr_addr (dir_wa),
        .i_wr_data (dir_wd_bits),
        .i_rd_addr (dir_ra),
        .o_rd_data (dir_rd)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        logic [CW-1:0] up;
        logic [CW-1:0] lf;
        logic [CW-1:0] dg;
        logic [CW-1:0] best;
        t_dir          dir;
        logic          miss;

        n_state     = r_state;
        n_ref_len   = r_ref_len;
        n_hyp_len   = r_hyp_len;
        n_ovf       = r_ovf;
        n_i         = r_i;
        n_j         = r_j;
        n_base      = r_base;
        n_diag      = r_diag;
        n_left      = r_left;
        n_sub       = r_sub;
        n_del       = r_del;
        n_ins       = r_ins;
        n_cor       = r_cor;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        ref_we      = 1'b0;
        hyp_we      = 1'b0;
        cost_we     = 1'b0;
        dir_we      = 1'b0;
        ref_wa      = r_ref_len[RAW-1:0];
        hyp_wa      = r_hyp_len[HAW-1:0];
        cost_wa     = r_j;
        cost_wd     = CW'(r_j);
        dir_wa      = dir_ra;
        dir_wd      = DIR_INS;

        miss = (ref_rd != hyp_rd);
        up   = cost_rd + CW'(1);
        lf   = r_left + CW'(1);
        dg   = r_diag + CW'(miss);
        if (up <= lf) begin
            if (up <= dg) begin
                best = up;
                dir  = DIR_DEL;
            end else begin
                best = dg;
                dir  = DIR_DIAG;
            end
        end else begin
            if (lf <= dg) begin
                best = lf;
                dir  = DIR_INS;
            end else begin
                best = dg;
                dir  = DIR_DIAG;
            end
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_data.op)
                        OP_LOAD_REF: begin
                            if (r_ref_len < MAX_R) begin
                                ref_we    = 1'b1;
                                n_ref_len = r_ref_len + IW'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        OP_LOAD_HYP: begin
                            if (r_hyp_len < MAX_H) begin
                                hyp_we    = 1'b1;
                                n_hyp_len = r_hyp_len + JW'(1);
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        OP_ALIGN: begin
                            n_j     = '0;
                            n_state = ST_INIT;
                        end
                        default: ;
                    endcase
                end
            end
            ST_INIT: begin
                cost_we = 1'b1;
                dir_we  = 1'b1;
                dir_wa  = DAW'(r_j);
                dir_wd  = (r_j == '0) ? DIR_NONE : DIR_INS;
                if (r_j == r_hyp_len) begin
                    if (r_ref_len == '0) begin
                        n_i     = '0;
                        n_base  = '0;
                        n_state = ST_TB_RD;
                    end else begin
                        n_i     = IW'(1);
                        n_base  = GC;
                        n_state = ST_ROW;
                    end
                end else begin
                    n_j = r_j + JW'(1);
                end
            end
            ST_ROW: begin
                cost_we = 1'b1;
                cost_wa = '0;
                cost_wd = CW'(r_i);
                dir_we  = 1'b1;
                dir_wa  = r_base;
                dir_wd  = DIR_DEL;
                n_diag  = CW'(i_m1);
                n_left  = CW'(r_i);
                if (r_hyp_len == '0) begin
                    n_j = '0;
                    if (r_i == r_ref_len) begin
                        n_state = ST_TB_RD;
                    end else begin
                        n_i    = r_i + IW'(1);
                        n_base = r_base + GC;
                    end
                end else begin
                    n_j     = JW'(1);
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                n_state = ST_CALC;
            end
            ST_CALC: begin
                cost_we = 1'b1;
                cost_wd = best;
                dir_we  = 1'b1;
                dir_wd  = dir;
                n_diag  = cost_rd;
                n_left  = best;
                if (r_j == r_hyp_len) begin
                    if (r_i == r_ref_len) begin
                        n_state = ST_TB_RD;
                    end else begin
                        n_i     = r_i + IW'(1);
                        n_base  = r_base + GC;
                        n_state = ST_ROW;
                    end
                end else begin
                    n_j     = r_j + JW'(1);
                    n_state = ST_RD;
                end
            end
            ST_TB_RD: begin
                if (r_i == '0 && r_j == '0) begin
                    n_state = ST_FIN;
                end else begin
                    n_state = ST_TB_EX;
                end
            end
            ST_TB_EX: begin
                n_state = ST_TB_RD;
                if (t_dir'(dir_rd) == DIR_DEL && r_i != '0) begin
                    n_del  = r_del + 32'd1;
                    n_i    = i_m1;
                    n_base = r_base - GC;
                end else if (t_dir'(dir_rd) == DIR_INS && r_j != '0) begin
                    n_ins = r_ins + 32'd1;
                    n_j   = j_m1;
                end else if (t_dir'(dir_rd) == DIR_DIAG && r_i != '0 && r_j != '0) begin
                    if (miss) begin
                        n_sub = r_sub + 32'd1;
                    end else begin
                        n_cor = r_cor + 32'd1;
                    end
                    n_i    = i_m1;
                    n_j    = j_m1;
                    n_base = r_base - GC;
                end else begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.sub_total = r_sub;
                    n_out.del_total = r_del;
                    n_out.ins_total = r_ins;
                    n_out.cor_total = r_cor;
                    n_out.dropped   = r_ovf;
                    n_out_valid     = 1'b1;
                    n_ref_len       = '0;
                    n_hyp_len       = '0;
                    n_ovf           = 1'b0;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ref_len   <= '0;
            r_hyp_len   <= '0;
            r_ovf       <= 1'b0;
            r_sub       <= '0;
            r_del       <= '0;
            r_ins       <= '0;
            r_cor       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ref_len   <= n_ref_len;
            r_hyp_len   <= n_hyp_len;
            r_ovf       <= n_ovf;
            r_sub       <= n_sub;
            r_del       <= n_del;
            r_ins       <= n_ins;
            r_cor       <= n_cor;
            r_out_valid <= n_out_valid;
        end
        r_i    <= n_i;
        r_j    <= n_j;
        r_base <= n_base;
        r_diag <= n_diag;
        r_left <= n_left;
        r_out  <= n_out;
    end

endmodule

`default_nettype wire

// File: src/wea_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none

module wea_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                          i_wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output      logic [WIDTH-1:0]                          o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire
